>>> design/golden_section_search_top_macros.svh
`ifndef GOLDEN_SECTION_SEARCH_TOP_MACROS_SVH
`define GOLDEN_SECTION_SEARCH_TOP_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define GSS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define GSS_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/gss_pkg.sv
package gss_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_WIDTH   = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = VALUE_WIDTH + FRAC_BITS;

  // 1/phi in Q0.32, cut down to FRAC_BITS fraction bits
  localparam logic [31:0] GOLDEN_Q32 = 32'h9E3779B9;
  localparam logic [FRAC_BITS-1:0] GOLDEN = FRAC_BITS'(GOLDEN_Q32 >> (32 - FRAC_BITS));
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ERROR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TOLERANCE = 2'd2;

  localparam logic signed [VALUE_WIDTH-1:0] LOWER_RESET = 32'sd0;
  localparam logic signed [VALUE_WIDTH-1:0] UPPER_RESET = 32'sd65536;
  localparam logic [TOL_WIDTH-1:0]          TOL_RESET   = 31'd66;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   mode;
    value_t error_value;
  } gss_req_t;

  typedef struct packed {
    value_t next_param;
    logic   done_res;
  } gss_rsp_t;

  typedef struct packed {
    value_t                lower_bound;
    value_t                upper_bound;
    logic [TOL_WIDTH-1:0]  stop_tolerance;
  } gss_cfg_t;

  // golden offset of one bracket, with its width magnitude and direction
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] q;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   desc;
  } gss_ofs_t;

endpackage

>>> design/gss_offset.sv
module gss_offset (
  input  gss_pkg::value_t  lo,
  input  gss_pkg::value_t  hi,
  output gss_pkg::gss_ofs_t ofs
);
  import gss_pkg::*;

  logic                   desc;
  logic [VALUE_WIDTH-1:0] mag;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      rounded;

  assign desc    = hi < lo;
  // the exact width always fits the unsigned word
  assign mag     = desc ? VALUE_WIDTH'(lo - hi) : VALUE_WIDTH'(hi - lo);
  assign prod    = PROD_W'(mag) * PROD_W'(GOLDEN);
  assign rounded = prod + HALF_LSB;

  assign ofs.q    = rounded[PROD_W-1:FRAC_BITS];
  assign ofs.mag  = mag;
  assign ofs.desc = desc;

endmodule

>>> design/gss_cfg.sv
module gss_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gss_pkg::VALUE_WIDTH-1:0]  cfg_data,
  output gss_pkg::gss_cfg_t                cfg
);
  import gss_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_bound    <= LOWER_RESET;
      cfg.upper_bound    <= UPPER_RESET;
      cfg.stop_tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOWER_BOUND:    cfg.lower_bound    <= cfg_data;
        REG_UPPER_BOUND:    cfg.upper_bound    <= cfg_data;
        REG_STOP_TOLERANCE: cfg.stop_tolerance <= cfg_data[TOL_WIDTH-1:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

endmodule

>>> design/gss_core.sv
module gss_core (
  input  logic              clk,
  input  logic              rst,
  input  gss_pkg::gss_cfg_t cfg,
  input  logic              req_valid,
  output logic              req_stall,
  input  gss_pkg::gss_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output gss_pkg::gss_rsp_t rsp
);
  import gss_pkg::*;

  localparam logic [2:0] P_LOWER = 3'd0;
  localparam logic [2:0] P_UPPER = 3'd1;
  localparam logic [2:0] P_C     = 3'd2;
  localparam logic [2:0] P_D     = 3'd3;
  localparam logic [2:0] P_NEW_C = 3'd4;
  localparam logic [2:0] P_NEW_D = 3'd5;

  value_t     left_edge, right_edge, inner_low, inner_high;
  value_t     err_inner_low, err_inner_high;
  logic [2:0] phase;

  value_t     left_edge_next, right_edge_next, inner_low_next, inner_high_next;
  value_t     err_inner_low_next, err_inner_high_next;
  logic [2:0] phase_next;
  gss_rsp_t   rsp_next;

  gss_ofs_t   ofs_full, ofs_keep_low, ofs_keep_high;
  value_t     c_full, d_full, c_new, d_new;
  value_t     err_lo_fresh, err_hi_fresh;
  logic       take_low;
  logic       accept;

  // full bracket, bracket [left, d] and bracket [c, right] side by side
  gss_offset u_ofs_full (.lo(left_edge), .hi(right_edge), .ofs(ofs_full));
  gss_offset u_ofs_keep_low (.lo(left_edge), .hi(inner_high), .ofs(ofs_keep_low));
  gss_offset u_ofs_keep_high (.lo(inner_low), .hi(right_edge), .ofs(ofs_keep_high));

  assign c_full = ofs_full.desc ? right_edge + ofs_full.q : right_edge - ofs_full.q;
  assign d_full = ofs_full.desc ? left_edge - ofs_full.q : left_edge + ofs_full.q;
  assign c_new  = ofs_keep_low.desc ? inner_high + ofs_keep_low.q
                                    : inner_high - ofs_keep_low.q;
  assign d_new  = ofs_keep_high.desc ? inner_low - ofs_keep_high.q
                                     : inner_low + ofs_keep_high.q;

  // use the fresh error in place of the stored one when comparing
  assign err_lo_fresh = (phase == P_NEW_C) ? req.error_value : err_inner_low;
  assign err_hi_fresh = (phase == P_D || phase == P_NEW_D) ? req.error_value
                                                           : err_inner_high;
  assign take_low     = err_lo_fresh < err_hi_fresh;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    left_edge_next      = left_edge;
    right_edge_next     = right_edge;
    inner_low_next      = inner_low;
    inner_high_next     = inner_high;
    err_inner_low_next  = err_inner_low;
    err_inner_high_next = err_inner_high;
    phase_next          = phase;
    rsp_next.next_param = right_edge;
    rsp_next.done_res   = 1'b0;

    if (req.mode == MODE_START) begin
      left_edge_next      = cfg.lower_bound;
      right_edge_next     = cfg.upper_bound;
      phase_next          = P_LOWER;
      rsp_next.next_param = cfg.lower_bound;
    end else begin
      case (phase)
        P_UPPER: begin
          inner_low_next      = c_full;
          rsp_next.next_param = c_full;
          phase_next          = P_C;
        end
        P_C: begin
          err_inner_low_next  = req.error_value;
          inner_high_next     = d_full;
          rsp_next.next_param = d_full;
          phase_next          = P_D;
        end
        P_D, P_NEW_C, P_NEW_D: begin
          if (take_low) begin
            right_edge_next     = inner_high;
            inner_high_next     = inner_low;
            err_inner_high_next = err_lo_fresh;
            err_inner_low_next  = err_lo_fresh;
            inner_low_next      = c_new;
            rsp_next.next_param = c_new;
            phase_next          = P_NEW_C;
            rsp_next.done_res   = (phase != P_D) &&
                                  (ofs_keep_low.mag < {1'b0, cfg.stop_tolerance});
          end else begin
            left_edge_next      = inner_low;
            inner_low_next      = inner_high;
            err_inner_low_next  = err_hi_fresh;
            err_inner_high_next = err_hi_fresh;
            inner_high_next     = d_new;
            rsp_next.next_param = d_new;
            phase_next          = P_NEW_D;
            rsp_next.done_res   = (phase != P_D) &&
                                  (ofs_keep_high.mag < {1'b0, cfg.stop_tolerance});
          end
        end
        default: begin
          // waiting for the lower bound error: propose the upper bound
          rsp_next.next_param = right_edge;
          phase_next          = P_UPPER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge      <= '0;
      right_edge     <= '0;
      inner_low      <= '0;
      inner_high     <= '0;
      err_inner_low  <= '0;
      err_inner_high <= '0;
      phase          <= P_LOWER;
      rsp_valid      <= 1'b0;
    end else begin
      if (accept) begin
        left_edge      <= left_edge_next;
        right_edge     <= right_edge_next;
        inner_low      <= inner_low_next;
        inner_high     <= inner_high_next;
        err_inner_low  <= err_inner_low_next;
        err_inner_high <= err_inner_high_next;
        phase          <= phase_next;
      end
      rsp_valid <= accept || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> design/golden_section_search_top.sv
// Golden-section search stepper.
// The result of an accepted request is registered: it is in the result register in the cycle after acceptance.
// Throughput: one request per cycle; req_stall rises only while a result waits stalled.
// The critical path is one 32x16 golden-ratio multiply per candidate bracket.
// Synchronous reset clears the bracket, inner points, errors and phase to zero,
// empties the result register and restores the config registers to their defaults.
module golden_section_search_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  gss_pkg::gss_req_t                req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output gss_pkg::gss_rsp_t                rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gss_pkg::VALUE_WIDTH-1:0]  cfg_data
);
  import gss_pkg::*;

  gss_cfg_t cfg;

  gss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> design/gss_checker.sv
`include "golden_section_search_top_macros.svh"

module gss_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  gss_pkg::gss_req_t                req,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  gss_pkg::gss_rsp_t                rsp
);
  import gss_pkg::*;

  logic req_take;

  assign req_take = req_valid && !req_stall;

  `GSS_ASSERT_NEXT(a_request_gives_result, clk, rst, req_take, rsp_valid, "accepted request gave no result")
  `GSS_ASSERT_NEXT(a_start_not_done, clk, rst, req_take && req.mode == MODE_START, !rsp.done_res, "start request flagged done")
  `GSS_ASSERT_SAME(a_stall_only_when_full, clk, rst, req_stall, rsp_valid && rsp_stall, "request stalled with result register free")
  `GSS_ASSERT_NEXT(a_no_spurious_result, clk, rst, !req_take && !(rsp_valid && rsp_stall), !rsp_valid, "result without request")
  `GSS_ASSERT_NEXT(a_result_held, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind golden_section_search_top gss_checker u_gss_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gss_pkg::*;

  localparam logic [63:0] GOLDEN_Q16 = 64'd40503;
  localparam logic [63:0] HALF_Q16   = 64'd32768;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 200;
  localparam int RAND_PHASES    = 8;
  localparam int RAND_PER_PHASE = 135;
  localparam int DIR_ROWS       = 32;

  typedef enum logic [2:0] {
    AWAIT_LOWER, AWAIT_UPPER, AWAIT_C, AWAIT_D, AWAIT_NEW_C, AWAIT_NEW_D
  } search_phase_e;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  mode;
    logic [31:0]           data;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  typed;
    value_t                exp_next;
    logic                  exp_done;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  gss_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gss_rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_WIDTH-1:0] cfg_data = '0;

  golden_section_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted search state and register copies
  value_t        cfg_lower = 32'sd0;
  value_t        cfg_upper = 32'sd65536;
  logic [30:0]   cfg_tol   = 31'd66;
  value_t        brk_lo = '0, brk_hi = '0, pt_c = '0, pt_d = '0;
  value_t        err_c = '0, err_d = '0;
  search_phase_e search_phase = AWAIT_LOWER;

  gss_rsp_t expected_results[$];
  value_t   last_proposed = '0;
  int       items_sent = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       quiet = 1'b0;
  int       hold_requests = 0;
  dir_row_t directed_rows [DIR_ROWS];

  initial forever #5 clk = ~clk;

  function automatic gss_ofs_t golden_split(value_t lo, value_t hi);
    gss_ofs_t    g;
    logic [63:0] prod;
    g.desc = hi < lo;
    g.mag  = g.desc ? lo - hi : hi - lo;
    prod   = 64'(g.mag) * GOLDEN_Q16 + HALF_Q16;
    g.q    = prod[47:16];
    return g;
  endfunction

  function automatic value_t inner_point_c();
    gss_ofs_t g;
    g = golden_split(brk_lo, brk_hi);
    return g.desc ? brk_hi + g.q : brk_hi - g.q;
  endfunction

  function automatic value_t inner_point_d();
    gss_ofs_t g;
    g = golden_split(brk_lo, brk_hi);
    return g.desc ? brk_lo - g.q : brk_lo + g.q;
  endfunction

  function automatic gss_rsp_t step_search(gss_req_t r);
    gss_rsp_t o;
    gss_ofs_t g;
    bit       check_done;
    o.done_res   = 1'b0;
    o.next_param = '0;
    if (r.mode == MODE_START) begin
      brk_lo       = cfg_lower;
      brk_hi       = cfg_upper;
      search_phase = AWAIT_LOWER;
      o.next_param = brk_lo;
    end else begin
      case (search_phase)
        AWAIT_UPPER: begin
          pt_c         = inner_point_c();
          o.next_param = pt_c;
          search_phase = AWAIT_C;
        end
        AWAIT_C: begin
          err_c        = r.error_value;
          pt_d         = inner_point_d();
          o.next_param = pt_d;
          search_phase = AWAIT_D;
        end
        AWAIT_D, AWAIT_NEW_C, AWAIT_NEW_D: begin
          check_done = search_phase != AWAIT_D;
          // store the fresh error before comparing
          if (search_phase == AWAIT_NEW_C) err_c = r.error_value;
          else err_d = r.error_value;
          if (err_c < err_d) begin
            brk_hi       = pt_d;
            pt_d         = pt_c;
            err_d        = err_c;
            pt_c         = inner_point_c();
            o.next_param = pt_c;
            search_phase = AWAIT_NEW_C;
          end else begin
            brk_lo       = pt_c;
            pt_c         = pt_d;
            err_c        = err_d;
            pt_d         = inner_point_d();
            o.next_param = pt_d;
            search_phase = AWAIT_NEW_D;
          end
          if (check_done) begin
            g          = golden_split(brk_lo, brk_hi);
            o.done_res = g.mag < {1'b0, cfg_tol};
          end
        end
        default: begin
          o.next_param = brk_hi;
          search_phase = AWAIT_UPPER;
        end
      endcase
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  // hold valid high across back-to-back requests; drop it only for an idle gap
  task automatic send_req(input logic mode, input value_t err, input bit use_typed,
                          input gss_rsp_t typed_rsp);
    gss_rsp_t predicted;
    cfg_valid <= 1'b0;
    if (!quiet && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    req_valid <= 1'b1;
    req       <= '{mode: mode, error_value: err};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = step_search('{mode: mode, error_value: err});
    last_proposed = predicted.next_param;
    expected_results.push_back(use_typed ? typed_rsp : predicted);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LOWER_BOUND:    cfg_lower = data;
      REG_UPPER_BOUND:    cfg_upper = data;
      REG_STOP_TOLERANCE: cfg_tol   = data[30:0];
      default: ;
    endcase
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    gss_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result next_param=%0h done=%0b",
                                  rsp.next_param, rsp.done_res));
      end else begin
        want = expected_results.pop_front();
        if (rsp.next_param !== want.next_param)
          report_mismatch($sformatf("next_param got %0h want %0h",
                                    rsp.next_param, want.next_param));
        if (rsp.done_res !== want.done_res)
          report_mismatch($sformatf("done_res got %0b want %0b",
                                    rsp.done_res, want.done_res));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    value_t             lo, hi, e;
    logic [31:0]        tol_data;
    logic signed [63:0] span_lo, span, target, dd;
    int                 phase_start, n;

    directed_rows = '{
      // error before any start runs on the zero bracket
      '{ROW_REQ, MODE_ERROR, 32'h0000_0000, REG_LOWER_BOUND, 1'b1, 32'sh0000_0000, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h7fff_ffff, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h8000_0000, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0005, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0005, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_START, 32'h7fff_ffff, REG_LOWER_BOUND, 1'b1, 32'sh0000_0000, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h8000_0000, REG_LOWER_BOUND, 1'b1, 32'sh0001_0000, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0000, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'hffff_ffff, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0001, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'hffff_ffff, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0000, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      // widest bracket, largest tolerance, and a write to the spare index
      '{ROW_CFG, MODE_START, 32'h8000_0000, REG_LOWER_BOUND,    1'b0, 32'sh0, 1'b0},
      '{ROW_CFG, MODE_START, 32'h7fff_ffff, REG_UPPER_BOUND,    1'b0, 32'sh0, 1'b0},
      '{ROW_CFG, MODE_START, 32'h7fff_ffff, REG_STOP_TOLERANCE, 1'b0, 32'sh0, 1'b0},
      '{ROW_CFG, MODE_START, 32'h1234_5678, REG_UNUSED,         1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_START, 32'h0000_0000, REG_LOWER_BOUND, 1'b1, 32'sh8000_0000, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0000, REG_LOWER_BOUND, 1'b1, 32'sh7fff_ffff, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0100, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0200, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h8000_0000, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h7fff_ffff, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      // reversed bounds, zero tolerance (top data bit is masked off)
      '{ROW_CFG, MODE_START, 32'h7fff_ffff, REG_LOWER_BOUND,    1'b0, 32'sh0, 1'b0},
      '{ROW_CFG, MODE_START, 32'h8000_0000, REG_UPPER_BOUND,    1'b0, 32'sh0, 1'b0},
      '{ROW_CFG, MODE_START, 32'h8000_0000, REG_STOP_TOLERANCE, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_START, 32'h1234_5678, REG_LOWER_BOUND, 1'b1, 32'sh7fff_ffff, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0000, REG_LOWER_BOUND, 1'b1, 32'sh8000_0000, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0003, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0002, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'hffff_ff00, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'hffff_ff00, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0},
      '{ROW_REQ, MODE_ERROR, 32'h0000_0007, REG_LOWER_BOUND, 1'b0, 32'sh0, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_req(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].typed,
                 '{next_param: directed_rows[i].exp_next,
                   done_res: directed_rows[i].exp_done});
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      lo = value_t'($urandom_range(0, 1 << 23)) - (1 << 22);
      case (p)
        1: begin
          lo = 32'sh8000_0000;
          hi = 32'sh7fff_ffff;
        end
        4: begin
          lo = 32'sh7fff_ffff;
          hi = 32'sh8000_0000;
        end
        6: hi = lo;
        2, 5: hi = lo - value_t'($urandom_range(1, 1 << 21));
        default: hi = lo + value_t'($urandom_range(1, 1 << 21));
      endcase
      case ($urandom_range(3))
        0: tol_data = 32'h0;
        1: tol_data = 32'd66;
        2: tol_data = $urandom_range(1, 5000);
        default: tol_data = $urandom;
      endcase
      tol_data[31] = 1'($urandom_range(1));
      write_reg(REG_LOWER_BOUND, lo);
      write_reg(REG_UPPER_BOUND, hi);
      write_reg(REG_STOP_TOLERANCE, tol_data);

      quiet = (p == 3);
      // stall the result side for a long stretch while requests keep coming
      if (p == 5) hold_requests++;

      span_lo = (hi < lo) ? 64'(hi) : 64'(lo);
      span    = (hi < lo) ? 64'(lo) - 64'(hi) : 64'(hi) - 64'(lo);
      phase_start = items_sent;
      while (items_sent - phase_start < RAND_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          target = span_lo + 64'({$urandom, $urandom} % (span + 1));
          send_req(MODE_START, $urandom, 1'b0, '0);
          n = $urandom_range(4, 45);
          repeat (n) begin
            if ($urandom_range(9) == 0) begin
              e = $urandom;
            end else begin
              dd = 64'(last_proposed) - target;
              if (dd < 0) dd = -dd;
              dd = dd + 64'($urandom_range(3));
              e  = dd[31:0];
            end
            send_req(MODE_ERROR, e, 1'b0, '0);
          end
        end else begin
          send_req(1'($urandom_range(1)), $urandom, 1'b0, '0);
        end
      end
    end

    quiet = 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
